// ===== hw/rtl/orientational_correlation_accumulator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the orientational correlation accumulator
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef ORIENTATIONAL_CORRELATION_ACCUMULATOR_TOP_DEFINES_SVH
`define ORIENTATIONAL_CORRELATION_ACCUMULATOR_TOP_DEFINES_SVH

// Check that is switched off while the reset is applied.
`define OCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds while the reset is applied.
`define OCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/oca_pkg.sv =====
// ----------------------------------------------------------------------------
// Orientational correlation accumulator package
// Widths, codes, state encoding and fixed-point helpers.
// ----------------------------------------------------------------------------
package oca_pkg;

  localparam int BinW     = 10;
  localparam int EntW     = 11;
  localparam int PartW    = 16;
  localparam int LimW     = 17;
  localparam int VecW     = 16;
  localparam int OpW      = 17;
  localparam int ProdW    = 2 * OpW;
  localparam int DotW     = 34;
  localparam int SumW     = 48;
  localparam int CntW     = 32;
  localparam int NW       = CntW + 1;
  localparam int SAccW    = SumW + 1;
  localparam int DivW     = 50;
  localparam int MeanW    = DivW + 1;
  localparam int AccW     = 62;
  localparam int OutW     = 18;
  localparam int StepW    = 6;
  localparam int FracBits = 15;

  localparam logic [LimW-1:0] LimReset = LimW'(65536);

  localparam logic signed [AccW-1:0] OneFx = AccW'(1) <<< FracBits;
  localparam logic signed [AccW-1:0] K3    = AccW'(3);
  localparam logic signed [AccW-1:0] K5    = AccW'(5);
  localparam logic signed [AccW-1:0] K30   = AccW'(30);
  localparam logic signed [AccW-1:0] K35   = AccW'(35);
  localparam logic signed [AccW-1:0] K105  = AccW'(105);
  localparam logic signed [AccW-1:0] K231  = AccW'(231);
  localparam logic signed [AccW-1:0] K315  = AccW'(315);

  localparam logic ACT_ACC  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] GRP_BOTH = 2'd0;
  localparam logic [1:0] GRP_A    = 2'd1;
  localparam logic [1:0] GRP_B    = 2'd2;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DOT   = 11'b00000000100,
    S_CLAMP = 11'b00000001000,
    S_POW   = 11'b00000010000,
    S_WRITE = 11'b00000100000,
    S_RDA   = 11'b00001000000,
    S_RDB   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_POLY  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic [SumW-1:0] s1;
    logic [SumW-1:0] s2;
    logic [SumW-1:0] s4;
    logic [SumW-1:0] s6;
    logic [CntW-1:0] n;
  } entry_t;

  // Divide by 2^k, rounding to nearest with ties away from zero (k >= 1).
  function automatic logic signed [AccW-1:0] round_shift(input logic signed [AccW-1:0] v,
                                                         input int k);
    logic [AccW-1:0] mag;
    mag = v[AccW-1] ? AccW'(-v) : AccW'(v);
    mag = (mag + (AccW'(1) << (k - 1))) >> k;
    return v[AccW-1] ? -signed'(mag) : signed'(mag);
  endfunction

  function automatic logic signed [OutW-1:0] sat18(input logic signed [AccW-1:0] v);
    if (v > AccW'(131071)) begin
      return OutW'(131071);
    end else if (v < -AccW'(131072)) begin
      return OutW'(-131072);
    end
    return OutW'(v);
  endfunction

endpackage

// ===== hw/rtl/orientational_correlation_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Orientational correlation accumulator
// Per-bin, per-species sums of c, c^2, c^4, c^6 and pair counts with readout.
// ----------------------------------------------------------------------------
// Usage: input beats arrive on in_valid_i/in_stall_o, results leave on
// out_valid_o/out_stall_i, and the species boundary is written on
// cfg_valid_i/cfg_ready_o while the block is idle.
// An accumulate beat runs three dot product steps and three power
// steps on one shared 17x17 multiplier, a clamp step, a read-modify-write
// of one entry of the bin memory and the return to idle that takes the next beat.
// A readout beat runs two entry reads, four restoring divisions on one shared
// subtractor, seven polynomial steps, a load of the output register and the
// return to idle. A readout of an empty count skips the divisions and the
// polynomial steps.
// One item is worked on at a time; in_stall_o is high while it is.
// After reset a clearing pass writes zero to all 2048 memory entries, one per
// cycle, so no input beat is taken until the pass is done.
// A result waits in the output register while the receiver stalls; further
// accumulate beats are still taken, and a following readout holds in its
// last step until the register is free.
// ----------------------------------------------------------------------------
`include "orientational_correlation_accumulator_top_defines.svh"

module orientational_correlation_accumulator_top
  import oca_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LimW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [BinW-1:0]        lag_bin_i,
  input  logic [PartW-1:0]       particle_index_i,
  input  logic [1:0]             group_i,
  input  logic signed [VecW-1:0] ref_x_i,
  input  logic signed [VecW-1:0] ref_y_i,
  input  logic signed [VecW-1:0] ref_z_i,
  input  logic signed [VecW-1:0] cur_x_i,
  input  logic signed [VecW-1:0] cur_y_i,
  input  logic signed [VecW-1:0] cur_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BinW-1:0]        bin_out_o,
  output logic signed [OutW-1:0] mean_p1_o,
  output logic signed [OutW-1:0] mean_p2_o,
  output logic signed [OutW-1:0] mean_p4_o,
  output logic signed [OutW-1:0] mean_p6_o,
  output logic                   empty_flag_o
);

  state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [EntW-1:0] clr_q, clr_d;
  logic [LimW-1:0] lim_q, lim_d;
  logic out_valid_q, out_valid_d;

  logic [BinW-1:0] bin_q, bin_d;
  logic [1:0] grp_q, grp_d;
  logic [EntW-1:0] ent_q, ent_d;
  logic signed [VecW-1:0] vec_q [6];
  logic signed [DotW-1:0] dot_q, dot_d;
  logic signed [OpW-1:0] c_q, c_d, c2_q, c2_d, c4_q, c4_d, c6_q, c6_d;
  logic signed [SAccW-1:0] sum_q [4];
  logic signed [SAccW-1:0] sum_d [4];
  logic [NW-1:0] n_q, n_d;
  logic [1:0] k_q, k_d;
  logic [DivW-1:0] num_q, num_d;
  logic [NW-1:0] rem_q, rem_d;
  logic neg_q, neg_d;
  logic signed [MeanW-1:0] m_q [4];
  logic signed [MeanW-1:0] m_d [4];
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [OutW-1:0] p_q [4];
  logic signed [OutW-1:0] p_d [4];
  logic empty_q, empty_d;
  logic [BinW-1:0] ob_q, ob_d;
  logic signed [OutW-1:0] op_q [4];
  logic signed [OutW-1:0] op_d [4];
  logic oe_q, oe_d;

  entry_t mem [2**EntW];
  entry_t rdata_q, wdata;
  logic [EntW-1:0] addr;
  logic mem_we, mem_re;

  logic signed [OpW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic [ProdW-1:0] prod_rnd;
  logic signed [OpW-1:0] pw;
  logic [DotW-1:0] dmag;
  logic [DotW-1:0] cmag;
  logic [NW:0] trial;
  logic qbit;
  logic signed [AccW-1:0] m1w, m2w, m4w, m6w;
  logic [SAccW-1:0] smag;
  logic in_take, emit, use_a, use_b;
  logic wr_state;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && (state_q == S_IDLE);
  assign emit        = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign use_a       = (grp_q == GRP_BOTH) || (grp_q == GRP_A);
  assign use_b       = (grp_q == GRP_BOTH) || (grp_q == GRP_B);
  assign wr_state    = (state_q == S_CLEAR) || (state_q == S_WRITE);

  assign prod     = mul_a * mul_b;
  assign prod_rnd = ProdW'(prod) + ProdW'(1 << (FracBits - 1));
  assign pw       = signed'(prod_rnd[FracBits+OpW-1:FracBits]);

  assign m1w = AccW'(m_q[0]);
  assign m2w = AccW'(m_q[1]);
  assign m4w = AccW'(m_q[2]);
  assign m6w = AccW'(m_q[3]);

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_DOT) begin
      case (step_q)
        StepW'(0): begin
          mul_a = OpW'(vec_q[0]);
          mul_b = OpW'(vec_q[3]);
        end
        StepW'(1): begin
          mul_a = OpW'(vec_q[1]);
          mul_b = OpW'(vec_q[4]);
        end
        default: begin
          mul_a = OpW'(vec_q[2]);
          mul_b = OpW'(vec_q[5]);
        end
      endcase
    end else begin
      case (step_q)
        StepW'(0): begin
          mul_a = c_q;
          mul_b = c_q;
        end
        StepW'(1): begin
          mul_a = c2_q;
          mul_b = c2_q;
        end
        default: begin
          mul_a = c4_q;
          mul_b = c2_q;
        end
      endcase
    end
  end

  always_comb begin
    dmag  = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
    cmag  = (dmag + DotW'(1 << (FracBits - 1))) >> FracBits;
    if (cmag > DotW'(1 << FracBits)) begin
      cmag = DotW'(1 << FracBits);
    end
    smag  = sum_q[k_q][SAccW-1] ? SAccW'(-sum_q[k_q]) : SAccW'(sum_q[k_q]);
    trial = {rem_q, num_q[DivW-1]};
    qbit  = (trial >= {1'b0, n_q});
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    clr_d       = clr_q;
    lim_d       = lim_q;
    bin_d       = bin_q;
    grp_d       = grp_q;
    ent_d       = ent_q;
    dot_d       = dot_q;
    c_d         = c_q;
    c2_d        = c2_q;
    c4_d        = c4_q;
    c6_d        = c6_q;
    sum_d       = sum_q;
    n_d         = n_q;
    k_d         = k_q;
    num_d       = num_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    m_d         = m_q;
    acc_d       = acc_q;
    p_d         = p_q;
    empty_d     = empty_q;
    ob_d        = ob_q;
    op_d        = op_q;
    oe_d        = oe_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    addr        = ent_q;
    wdata       = rdata_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i) begin
      lim_d = cfg_data_i;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        addr   = clr_q;
        wdata  = '0;
        clr_d  = clr_q + EntW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          bin_d  = lag_bin_i;
          grp_d  = group_i;
          step_d = '0;
          mem_re = 1'b1;
          if (action_i == ACT_ACC) begin
            ent_d   = {~({1'b0, particle_index_i} < lim_q), lag_bin_i};
            addr    = ent_d;
            dot_d   = '0;
            state_d = S_DOT;
          end else begin
            addr    = {1'b0, lag_bin_i};
            sum_d   = '{default: '0};
            n_d     = '0;
            state_d = S_RDA;
          end
        end
      end
      S_DOT: begin
        dot_d  = dot_q + DotW'(prod);
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(2)) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        c_d     = dot_q[DotW-1] ? -signed'(OpW'(cmag)) : signed'(OpW'(cmag));
        step_d  = '0;
        state_d = S_POW;
      end
      S_POW: begin
        step_d = step_q + StepW'(1);
        case (step_q)
          StepW'(0): c2_d = pw;
          StepW'(1): c4_d = pw;
          default: begin
            c6_d    = pw;
            state_d = S_WRITE;
          end
        endcase
      end
      S_WRITE: begin
        // A saturated pair count freezes the entry.
        mem_we   = (rdata_q.n != '1);
        wdata.s1 = rdata_q.s1 + SumW'(c_q);
        wdata.s2 = rdata_q.s2 + SumW'(c2_q);
        wdata.s4 = rdata_q.s4 + SumW'(c4_q);
        wdata.s6 = rdata_q.s6 + SumW'(c6_q);
        wdata.n  = rdata_q.n + CntW'(1);
        state_d  = S_IDLE;
      end
      S_RDA: begin
        if (use_a) begin
          sum_d[0] = sum_q[0] + SAccW'(signed'(rdata_q.s1));
          sum_d[1] = sum_q[1] + SAccW'(signed'(rdata_q.s2));
          sum_d[2] = sum_q[2] + SAccW'(signed'(rdata_q.s4));
          sum_d[3] = sum_q[3] + SAccW'(signed'(rdata_q.s6));
          n_d      = n_q + NW'(rdata_q.n);
        end
        mem_re  = 1'b1;
        addr    = {1'b1, bin_q};
        state_d = S_RDB;
      end
      S_RDB: begin
        if (use_b) begin
          sum_d[0] = sum_q[0] + SAccW'(signed'(rdata_q.s1));
          sum_d[1] = sum_q[1] + SAccW'(signed'(rdata_q.s2));
          sum_d[2] = sum_q[2] + SAccW'(signed'(rdata_q.s4));
          sum_d[3] = sum_q[3] + SAccW'(signed'(rdata_q.s6));
          n_d      = n_q + NW'(rdata_q.n);
        end
        step_d = '0;
        k_d    = '0;
        if (n_d == '0) begin
          p_d     = '{default: '0};
          empty_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          empty_d = 1'b0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        step_d = step_q + StepW'(1);
        if (step_q == '0) begin
          num_d = DivW'(smag) + DivW'(n_q >> 1);
          rem_d = '0;
          neg_d = sum_q[k_q][SAccW-1];
        end else begin
          rem_d = qbit ? NW'(trial - {1'b0, n_q}) : NW'(trial);
          num_d = {num_q[DivW-2:0], qbit};
          if (step_q == StepW'(DivW)) begin
            m_d[k_q] = neg_q ? -signed'(MeanW'(num_d)) : signed'(MeanW'(num_d));
            step_d   = '0;
            k_d      = k_q + 2'd1;
            if (k_q == 2'd3) begin
              state_d = S_POLY;
            end
          end
        end
      end
      S_POLY: begin
        step_d = step_q + StepW'(1);
        case (step_q)
          StepW'(0): p_d[0] = sat18(m1w <<< 1);
          StepW'(1): p_d[1] = sat18(K3 * m2w - OneFx);
          StepW'(2): acc_d  = K35 * m4w - K30 * m2w + K3 * OneFx;
          StepW'(3): p_d[2] = sat18(round_shift(acc_q, 2));
          StepW'(4): acc_d  = K231 * m6w - K315 * m4w;
          StepW'(5): acc_d  = acc_q + K105 * m2w - K5 * OneFx;
          default: begin
            p_d[3]  = sat18(round_shift(acc_q, 3));
            state_d = S_EMIT;
          end
        endcase
      end
      S_EMIT: begin
        if (emit) begin
          ob_d        = bin_q;
          op_d        = p_q;
          oe_d        = empty_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      lim_q       <= LimReset;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      vec_q[0] <= ref_x_i;
      vec_q[1] <= ref_y_i;
      vec_q[2] <= ref_z_i;
      vec_q[3] <= cur_x_i;
      vec_q[4] <= cur_y_i;
      vec_q[5] <= cur_z_i;
    end
    bin_q   <= bin_d;
    grp_q   <= grp_d;
    ent_q   <= ent_d;
    dot_q   <= dot_d;
    c_q     <= c_d;
    c2_q    <= c2_d;
    c4_q    <= c4_d;
    c6_q    <= c6_d;
    sum_q   <= sum_d;
    n_q     <= n_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    m_q     <= m_d;
    acc_q   <= acc_d;
    p_q     <= p_d;
    empty_q <= empty_d;
    ob_q    <= ob_d;
    op_q    <= op_d;
    oe_q    <= oe_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_out_o    = ob_q;
  assign mean_p1_o    = op_q[0];
  assign mean_p2_o    = op_q[1];
  assign mean_p4_o    = op_q[2];
  assign mean_p6_o    = op_q[3];
  assign empty_flag_o = oe_q;

  `OCA_ASSERT(a_busy_after_take, (in_valid_i && !in_stall_o) |=> in_stall_o, "busy take")
  `OCA_ASSERT(a_no_out_in_clear, (state_q == S_CLEAR) |-> !out_valid_o, "result during clearing")
  `OCA_ASSERT_ALWAYS(a_write_states, mem_we |-> wr_state, "stray memory write")

endmodule

// ===== verif/tb_orientational_correlation_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the orientational correlation accumulator
// Drives accumulate and readout beats with random gaps on both channels,
// predicts each readout from its own copy of the bin sums and the species
// boundary or from a directed row, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_orientational_correlation_accumulator_top import oca_pkg::*; ();

  localparam int     IdleLimit = 20000;
  localparam int     HoldCycles = 600;
  localparam longint OneQ = 64'sd32768;

  typedef struct {
    logic                   action;
    logic [BinW-1:0]        bin;
    logic [PartW-1:0]       part;
    logic [1:0]             group;
    logic signed [VecW-1:0] rx, ry, rz, cx, cy, cz;
  } pair_beat_t;

  typedef struct {
    logic [BinW-1:0]        bin;
    logic signed [OutW-1:0] p1, p2, p4, p6;
    logic                   empty;
  } means_t;

  typedef struct {
    pair_beat_t beat;
    bit         known;
    means_t     want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LimW-1:0]        cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   action = ACT_ACC;
  logic [BinW-1:0]        lag_bin = '0;
  logic [PartW-1:0]       particle_index = '0;
  logic [1:0]             group = GRP_BOTH;
  logic signed [VecW-1:0] ref_x = '0, ref_y = '0, ref_z = '0;
  logic signed [VecW-1:0] cur_x = '0, cur_y = '0, cur_z = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b1;
  logic [BinW-1:0]        bin_out;
  logic signed [OutW-1:0] mean_p1, mean_p2, mean_p4, mean_p6;
  logic                   empty_flag;

  // Model state: entry index is {species, bin}, species A is 0.
  logic [SumW-1:0] bin_cos1 [2048];
  logic [SumW-1:0] bin_cos2 [2048];
  logic [SumW-1:0] bin_cos4 [2048];
  logic [SumW-1:0] bin_cos6 [2048];
  logic [CntW-1:0] bin_pairs [2048];
  logic [LimW-1:0] species_limit = LimReset;

  means_t   pending_means[$];
  dir_row_t dir_tbl[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       hold_req = 1'b0;
  bit       no_idle = 1'b0;

  orientational_correlation_accumulator_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .lag_bin_i        (lag_bin),
    .particle_index_i (particle_index),
    .group_i          (group),
    .ref_x_i          (ref_x),
    .ref_y_i          (ref_y),
    .ref_z_i          (ref_z),
    .cur_x_i          (cur_x),
    .cur_y_i          (cur_y),
    .cur_z_i          (cur_z),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .bin_out_o        (bin_out),
    .mean_p1_o        (mean_p1),
    .mean_p2_o        (mean_p2),
    .mean_p4_o        (mean_p4),
    .mean_p6_o        (mean_p6),
    .empty_flag_o     (empty_flag)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // v / 2^k, nearest with ties away from zero; k <= 0 scales up.
  function automatic longint round_k(input longint v, input int k);
    bit              neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? longint'(-v) : longint'(v);
    if (mag > (64'd1 << 60)) mag = 64'd1 << 60;
    if (k <= 0) begin
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      mag = mag << (-k);
    end else begin
      mag = (mag + (64'd1 << (k - 1))) >> k;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint rounded_mean(input longint s, input longint unsigned n);
    longint unsigned mag, q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag + n / 2) / n;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [OutW-1:0] clip18(input longint v);
    if (v > 131071) return 18'sd131071;
    if (v < -131072) return -18'sd131072;
    return v[OutW-1:0];
  endfunction

  // Updates the bin sums for an accumulate and forms the result of a readout.
  function automatic bit predict_beat(input pair_beat_t b, output means_t r);
    logic [EntW-1:0] e;
    longint          dot, c, c2, c4, c6, s1, s2, s4, s6, m1, m2, m4, m6;
    longint unsigned n;
    r = '{b.bin, '0, '0, '0, '0, 1'b1};
    if (b.action == ACT_ACC) begin
      e = {({1'b0, b.part} < species_limit) ? 1'b0 : 1'b1, b.bin};
      if (bin_pairs[e] == '1) return 1'b0;
      dot = longint'(b.rx) * longint'(b.cx) + longint'(b.ry) * longint'(b.cy)
          + longint'(b.rz) * longint'(b.cz);
      c = round_k(dot, 15);
      if (c > OneQ) c = OneQ;
      if (c < -OneQ) c = -OneQ;
      c2 = round_k(c * c, 15);
      c4 = round_k(c2 * c2, 15);
      c6 = round_k(c4 * c2, 15);
      bin_cos1[e] += c[SumW-1:0];
      bin_cos2[e] += c2[SumW-1:0];
      bin_cos4[e] += c4[SumW-1:0];
      bin_cos6[e] += c6[SumW-1:0];
      bin_pairs[e] += 1;
      return 1'b0;
    end
    s1 = 0; s2 = 0; s4 = 0; s6 = 0; n = 0;
    if (b.group != 2'd3) begin
      for (int sp = 0; sp < 2; sp++) begin
        if ((b.group == GRP_A && sp == 1) || (b.group == GRP_B && sp == 0)) continue;
        e = {sp[0], b.bin};
        s1 += longint'($signed(bin_cos1[e]));
        s2 += longint'($signed(bin_cos2[e]));
        s4 += longint'($signed(bin_cos4[e]));
        s6 += longint'($signed(bin_cos6[e]));
        n += bin_pairs[e];
      end
    end
    if (n != 0) begin
      m1 = rounded_mean(s1, n);
      m2 = rounded_mean(s2, n);
      m4 = rounded_mean(s4, n);
      m6 = rounded_mean(s6, n);
      r.p1 = clip18(round_k(m1, -1));
      r.p2 = clip18(round_k(3 * m2 - OneQ, 0));
      r.p4 = clip18(round_k(35 * m4 - 30 * m2 + 3 * OneQ, 2));
      r.p6 = clip18(round_k(231 * m6 - 315 * m4 + 105 * m2 - 5 * OneQ, 3));
      r.empty = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 100) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VecW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2, 3, 4, 5: return VecW'($urandom());
      default: return 16'(int'($urandom_range(0, 37000)) - 18500);
    endcase
  endfunction

  function automatic pair_beat_t random_beat();
    pair_beat_t b;
    b.action = ($urandom_range(0, 99) < 12) ? ACT_READ : ACT_ACC;
    b.bin = ($urandom_range(0, 9) < 8) ? BinW'($urandom_range(0, 7)) : BinW'($urandom());
    b.part = ($urandom_range(0, 3) == 0) ? PartW'(species_limit + $urandom_range(0, 4) - 2)
                                         : PartW'($urandom());
    b.group = 2'($urandom_range(0, 3));
    b.rx = rand_comp();
    b.ry = rand_comp();
    b.rz = rand_comp();
    if ($urandom_range(0, 9) < 3) begin
      // Current vector copies the reference, with x optionally negated.
      b.cx = $urandom_range(0, 1) ? b.rx : -b.rx;
      b.cy = b.ry;
      b.cz = b.rz;
    end else begin
      b.cx = rand_comp();
      b.cy = rand_comp();
      b.cz = rand_comp();
    end
    return b;
  endfunction

  task automatic send_beat(input pair_beat_t b, input bit known, input means_t want);
    int     gap;
    means_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action <= b.action;
    lag_bin <= b.bin;
    particle_index <= b.part;
    group <= b.group;
    ref_x <= b.rx;
    ref_y <= b.ry;
    ref_z <= b.rz;
    cur_x <= b.cx;
    cur_y <= b.cy;
    cur_z <= b.cz;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (predict_beat(b, r)) pending_means.push_back(known ? want : r);
  endtask

  task automatic write_limit(input logic [LimW-1:0] v);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    // An accumulate may still be in flight after the last result.
    repeat (30) @(posedge clk_i);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    species_limit = v;
  endtask

  task automatic add_row(input logic act, input int bin, input int part, input logic [1:0] grp,
                         input int rx, input int ry, input int rz,
                         input int cx, input int cy, input int cz,
                         input bit known, input int p1, input int p2, input int p4,
                         input int p6, input bit empty);
    dir_row_t row;
    row.beat = '{act, BinW'(bin), PartW'(part), grp, VecW'(rx), VecW'(ry), VecW'(rz),
                 VecW'(cx), VecW'(cy), VecW'(cz)};
    row.known = known;
    row.want = '{BinW'(bin), OutW'(p1), OutW'(p2), OutW'(p4), OutW'(p6), empty};
    dir_tbl.push_back(row);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    means_t w;
    if (out_valid && !out_stall) begin
      if (pending_means.size() == 0) begin
        report_mismatch("unexpected result beat, bin", bin_out, -1);
      end else begin
        w = pending_means.pop_front();
        if (bin_out !== w.bin) report_mismatch("bin_out", bin_out, w.bin);
        if (mean_p1 !== w.p1) report_mismatch("mean_p1", mean_p1, w.p1);
        if (mean_p2 !== w.p2) report_mismatch("mean_p2", mean_p2, w.p2);
        if (mean_p4 !== w.p4) report_mismatch("mean_p4", mean_p4, w.p4);
        if (mean_p6 !== w.p6) report_mismatch("mean_p6", mean_p6, w.p6);
        if (empty_flag !== w.empty) report_mismatch("empty_flag", empty_flag, w.empty);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin : stall_gen
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        len = HoldCycles;
      end else begin
        len = pick_gap();
      end
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_orientational_correlation_accumulator_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [LimW-1:0] limits [7];
    int              wait_cycles;
    means_t          none;
    for (int i = 0; i < 2048; i++) begin
      bin_cos1[i] = '0;
      bin_cos2[i] = '0;
      bin_cos4[i] = '0;
      bin_cos6[i] = '0;
      bin_pairs[i] = '0;
    end
    none = '{'0, '0, '0, '0, '0, 1'b0};
    limits = '{17'd0, 17'd65536, 17'd1, 17'd32768, 17'd65535,
               LimW'($urandom_range(0, 65536)), 17'd65536};

    // Boundary at reset puts every particle in species A.
    add_row(ACT_READ, 0, 0, GRP_BOTH, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(ACT_READ, 1023, 0, 2'd3, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(ACT_ACC, 0, 0, GRP_BOTH, -32768, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 0, 0, GRP_A, 0, 0, 0, 0, 0, 0, 1, 65536, 65536, 65536, 65536, 0);
    add_row(ACT_READ, 0, 0, GRP_B, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(ACT_READ, 0, 0, GRP_BOTH, 0, 0, 0, 0, 0, 0, 1, 65536, 65536, 65536, 65536, 0);
    add_row(ACT_ACC, 1, 65535, GRP_BOTH, -32768, -32768, -32768, -32768, -32768, -32768,
            0, 0, 0, 0, 0, 0);
    add_row(ACT_ACC, 1, 1, GRP_BOTH, 32767, 0, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_ACC, 1, 2, GRP_BOTH, 32767, 32767, 32767, -32768, -32768, -32768,
            0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 1, 0, GRP_A, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_ACC, 2, 7, GRP_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 2, 0, GRP_A, 0, 0, 0, 0, 0, 0, 1, 0, -32768, 24576, -20480, 0);
    add_row(ACT_ACC, 1023, 32768, GRP_BOTH, 0, 32767, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_ACC, 1023, 100, GRP_BOTH, 0, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 1023, 0, GRP_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 1023, 0, 2'd3, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1);
    add_row(ACT_ACC, 3, 40000, GRP_BOTH, 23170, -23170, 0, 23170, 23170, 5000,
            0, 0, 0, 0, 0, 0);
    add_row(ACT_ACC, 3, 9, GRP_BOTH, 18918, 18918, -18918, -18918, 18918, 18918,
            0, 0, 0, 0, 0, 0);
    add_row(ACT_READ, 3, 0, GRP_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tbl[i]) send_beat(dir_tbl[i].beat, dir_tbl[i].known, dir_tbl[i].want);

    foreach (limits[p]) begin
      write_limit(limits[p]);
      no_idle = (p == 3);
      for (int i = 0; i < 250; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;
        send_beat(random_beat(), 1'b0, none);
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending_means.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);
    if (pending_means.size() != 0) report_mismatch("results never seen", 0,
                                                   pending_means.size());
    if (errors == 0) begin
      $display("tb_orientational_correlation_accumulator_top OK");
    end else begin
      $display("tb_orientational_correlation_accumulator_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/oca_pkg.sv
hw/rtl/orientational_correlation_accumulator_top.sv
verif/tb_orientational_correlation_accumulator_top.sv
